// File: rtl/dwpi_pkg.sv
// Shared types, widths and constants of the dual wheel PI speed controller.
// Used by every module under rtl; depends on nothing else.
package dwpi_pkg;

    localparam int HIST_DEPTH = 10;
    localparam int PERIOD_W   = 16;
    localparam int SUM_W      = 20;
    localparam int RPM_W      = 16;
    localparam int ERR_W      = 17;
    localparam int DUTY_W     = 14;
    localparam int GAIN_W     = 8;
    localparam int CONV_W     = 24;
    localparam int DIV_W      = 24;
    localparam int COEF_W     = GAIN_W + 2;
    localparam int ACC_W      = 28;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(DIV_W - (DIV_W - SUM_W));
    localparam logic [STEP_W-1:0] RPM_STEPS  = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] MAC_STEPS  = STEP_W'(2 * COEF_W);
    localparam logic [STEP_W-1:0] MAC_SWITCH = STEP_W'(COEF_W + 1);
    localparam logic [STEP_W-1:0] MAC_LAST   = STEP_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PGAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONV    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd6;

    localparam logic [RPM_W-1:0]  TARGET_RESET  = 16'd120;
    localparam logic [GAIN_W-1:0] PGAIN_RESET   = 8'd9;
    localparam logic [GAIN_W-1:0] IGAIN_RESET   = 8'd3;
    localparam logic [DUTY_W-1:0] FLOOR_RESET   = 14'd2;
    localparam logic [DUTY_W-1:0] CEILING_RESET = 14'd9999;
    localparam logic [CONV_W-1:0] CONV_RESET    = 24'd250000;

    typedef struct packed {
        logic [RPM_W-1:0]  target;
        logic [GAIN_W-1:0] pgain;
        logic [GAIN_W-1:0] igain;
        logic [DUTY_W-1:0] floor_duty;
        logic [DUTY_W-1:0] ceil_duty;
        logic [CONV_W-1:0] conv;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic avg_go;
        logic rpm_go;
        logic mac_go;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic mac_busy;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_RUN,
        ST_RPM_GO,
        ST_RPM_RUN,
        ST_MAC_GO,
        ST_MAC_RUN,
        ST_COMMIT
    } state_t;

endpackage

// File: rtl/dwpi_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dwpi_pkg for widths.
module dwpi_div
    import dwpi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [RPM_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    logic [RPM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [RPM_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [RPM_W:0]    partial;
    logic [RPM_W+1:0]  diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        partial  = {rem_reg, dvd_reg[DIV_W-1]};
        diff     = {1'b0, partial} - {2'b00, dsr_reg};
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
            cnt_next = steps;
        end
        else if (cnt_reg != '0)
        begin
            // For a nonzero divisor the remainder stays below it, so 16 bits hold it.
            if (!diff[RPM_W+1])
            begin
                rem_next = diff[RPM_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[RPM_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dvd_reg;

endmodule

// File: rtl/dwpi_mac.sv
// Bit-serial signed multiply-accumulate: base + coef_a * mcand_a + coef_b * mcand_b.
// One coefficient bit per cycle; depends on dwpi_pkg for widths.
module dwpi_mac
    import dwpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DUTY_W-1:0]        base,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [ERR_W-1:0]  mcand_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [ERR_W-1:0]  mcand_b,
    output logic                     busy,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [COEF_W-1:0]       coef_reg, coef_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic                    sign_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        coef_reg  <= coef_next;
    end

    always_comb
    begin
        sign_step  = (cnt_reg == MAC_SWITCH) || (cnt_reg == MAC_LAST);
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        coef_next  = coef_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            acc_next   = $signed({{(ACC_W-DUTY_W){1'b0}}, base});
            mcand_next = $signed({{(ACC_W-ERR_W){mcand_a[ERR_W-1]}}, mcand_a});
            coef_next  = coef_a;
            cnt_next   = MAC_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            // The top coefficient bit carries negative weight.
            if (coef_reg[0])
            begin
                acc_next = sign_step ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            end
            if (cnt_reg == MAC_SWITCH)
            begin
                mcand_next = $signed({{(ACC_W-ERR_W){mcand_b[ERR_W-1]}}, mcand_b});
                coef_next  = coef_b;
            end
            else
            begin
                mcand_next = mcand_reg <<< 1;
                coef_next  = coef_reg >> 1;
            end
            cnt_next = cnt_reg - STEP_W'(1);
        end
    end

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;

endmodule

// File: rtl/dwpi_lane.sv
// One wheel: period history with running sum, speed conversion, PI step and clamp.
// Depends on dwpi_pkg, dwpi_div and dwpi_mac.
module dwpi_lane
    import dwpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  cfg_t                    cfg,
    input  logic [PERIOD_W-1:0]     period,
    output stat_t                   stat,
    output logic [DUTY_W-1:0]       duty,
    output logic [RPM_W-1:0]        rpm,
    output logic signed [ERR_W-1:0] error
);

    logic [PERIOD_W-1:0]     hist_reg [HIST_DEPTH];
    logic [SUM_W-1:0]        sum_reg;
    logic [DUTY_W-1:0]       drive_reg;
    logic signed [ERR_W-1:0] last_err_reg;
    logic [RPM_W-1:0]        avg_reg;
    logic [RPM_W-1:0]        rpm_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic [RPM_W-1:0]        div_divisor;
    logic [STEP_W-1:0]       div_steps;
    logic                    div_busy;
    logic [DIV_W-1:0]        quot;
    logic [RPM_W-1:0]        rpm_sat;
    logic signed [COEF_W-1:0] k_sum;
    logic signed [COEF_W-1:0] k_diff;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lo_lim;
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] clamped;

    // The history is a shift line: its last tap is the period that leaves the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            sum_reg      <= '0;
            drive_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                hist_reg[0] <= period;
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                sum_reg <= sum_reg - {{(SUM_W-PERIOD_W){1'b0}}, hist_reg[HIST_DEPTH-1]}
                                   + {{(SUM_W-PERIOD_W){1'b0}}, period};
            end
            if (ctrl.commit)
            begin
                drive_reg    <= clamped[DUTY_W-1:0];
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rpm_go)
        begin
            avg_reg <= quot[RPM_W-1:0];
        end
        if (ctrl.mac_go)
        begin
            rpm_reg <= rpm_sat;
            err_reg <= $signed({1'b0, cfg.target} - {1'b0, rpm_sat});
        end
    end

    always_comb
    begin
        div_start = ctrl.avg_go || ctrl.rpm_go;
        if (ctrl.avg_go)
        begin
            div_dividend = {sum_reg, {(DIV_W-SUM_W){1'b0}}};
            div_divisor  = RPM_W'(HIST_DEPTH);
            div_steps    = AVG_STEPS;
        end
        else
        begin
            div_dividend = cfg.conv;
            div_divisor  = quot[RPM_W-1:0];
            div_steps    = RPM_STEPS;
        end
    end

    dwpi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (quot)
    );

    // A zero average period or a quotient above 16 bits reads as full speed.
    assign rpm_sat = ((avg_reg == '0) || (quot[DIV_W-1:RPM_W] != '0)) ? '1
                                                                      : quot[RPM_W-1:0];

    assign k_sum  = $signed({2'b00, cfg.pgain} + {2'b00, cfg.igain});
    assign k_diff = $signed({2'b00, cfg.igain} - {2'b00, cfg.pgain});

    // The previous error is known at once, so its product is formed first.
    dwpi_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.mac_go),
        .base    (drive_reg),
        .coef_a  (k_diff),
        .mcand_a (last_err_reg),
        .coef_b  (k_sum),
        .mcand_b (err_reg),
        .busy    (mac_busy),
        .acc     (acc)
    );

    // The floor test comes first, so a floor above the ceiling wins for acc below it.
    always_comb
    begin
        lo_lim = $signed({{(ACC_W-DUTY_W){1'b0}}, cfg.floor_duty});
        hi_lim = $signed({{(ACC_W-DUTY_W){1'b0}}, cfg.ceil_duty});
        priority if (acc < lo_lim)
        begin
            clamped = lo_lim;
        end
        else if (acc > hi_lim)
        begin
            clamped = hi_lim;
        end
        else
        begin
            clamped = acc;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.mac_busy = mac_busy;
    assign duty  = clamped[DUTY_W-1:0];
    assign rpm   = rpm_reg;
    assign error = err_reg;

endmodule

// File: rtl/dual_wheel_pi_speed_controller.sv
// Top level of the dual wheel PI speed controller: register file, sequencer, result register.
// Depends on dwpi_pkg and two instances of dwpi_lane.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   left_period, right_period
//   result    out        result_valid/result_stall  duties, rpms, errors
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An enabled request runs from acceptance to a waiting result through the serial divider for
// the window average, the serial divider again for the speed quotient and then the serial
// multiply-accumulate, with sequencing states in between. The next request can be taken in
// the cycle after the result is written, so requests are worked on one at a time.
// A request that arrives while the loop is disabled is taken and dropped, and gives no
// result. Both wheels run side by side in their own lanes.
// Reset clears the histories, sums, duties and previous errors at once.
// item_stall is high while a request is being worked on; a finished result waits in the
// output register under result_stall, and the next request may be taken meanwhile.
module dual_wheel_pi_speed_controller
    import dwpi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [PERIOD_W-1:0]         left_period,
    input  logic [PERIOD_W-1:0]         right_period,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [DUTY_W-1:0]           left_duty,
    output logic [DUTY_W-1:0]           right_duty,
    output logic [RPM_W-1:0]            left_rpm,
    output logic [RPM_W-1:0]            right_rpm,
    output logic signed [ERR_W-1:0]     left_error,
    output logic signed [ERR_W-1:0]     right_error,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    cfg_t   cfg_reg;
    logic   enable_reg;
    state_t state_reg, state_next;
    ctrl_t  ctrl;
    stat_t  left_stat;
    stat_t  right_stat;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    logic [DUTY_W-1:0]       l_duty, r_duty;
    logic [RPM_W-1:0]        l_rpm, r_rpm;
    logic signed [ERR_W-1:0] l_err, r_err;

    logic [DUTY_W-1:0]       left_duty_reg, right_duty_reg;
    logic [RPM_W-1:0]        left_rpm_reg, right_rpm_reg;
    logic signed [ERR_W-1:0] left_err_reg, right_err_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target     <= TARGET_RESET;
            cfg_reg.pgain      <= PGAIN_RESET;
            cfg_reg.igain      <= IGAIN_RESET;
            cfg_reg.floor_duty <= FLOOR_RESET;
            cfg_reg.ceil_duty  <= CEILING_RESET;
            cfg_reg.conv       <= CONV_RESET;
            enable_reg         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET:  cfg_reg.target     <= cfg_data[RPM_W-1:0];
                REG_PGAIN:   cfg_reg.pgain      <= cfg_data[GAIN_W-1:0];
                REG_IGAIN:   cfg_reg.igain      <= cfg_data[GAIN_W-1:0];
                REG_FLOOR:   cfg_reg.floor_duty <= cfg_data[DUTY_W-1:0];
                REG_CEILING: cfg_reg.ceil_duty  <= cfg_data[DUTY_W-1:0];
                REG_CONV:    cfg_reg.conv       <= cfg_data[CONV_W-1:0];
                REG_ENABLE:  enable_reg         <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        item_stall     = 1'b1;
        out_valid_next = out_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                // A request taken while disabled is dropped without touching any state.
                if (item_valid && enable_reg)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_AVG_GO;
                end
            end
            ST_AVG_GO:
            begin
                ctrl.avg_go = 1'b1;
                state_next  = ST_AVG_RUN;
            end
            ST_AVG_RUN:
            begin
                if (!left_stat.div_busy && !right_stat.div_busy)
                begin
                    state_next = ST_RPM_GO;
                end
            end
            ST_RPM_GO:
            begin
                ctrl.rpm_go = 1'b1;
                state_next  = ST_RPM_RUN;
            end
            ST_RPM_RUN:
            begin
                if (!left_stat.div_busy && !right_stat.div_busy)
                begin
                    state_next = ST_MAC_GO;
                end
            end
            ST_MAC_GO:
            begin
                ctrl.mac_go = 1'b1;
                state_next  = ST_MAC_RUN;
            end
            ST_MAC_RUN:
            begin
                if (!left_stat.mac_busy && !right_stat.mac_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    dwpi_lane u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cfg    (cfg_reg),
        .period (left_period),
        .stat   (left_stat),
        .duty   (l_duty),
        .rpm    (l_rpm),
        .error  (l_err)
    );

    dwpi_lane u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cfg    (cfg_reg),
        .period (right_period),
        .stat   (right_stat),
        .duty   (r_duty),
        .rpm    (r_rpm),
        .error  (r_err)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            left_duty_reg  <= l_duty;
            right_duty_reg <= r_duty;
            left_rpm_reg   <= l_rpm;
            right_rpm_reg  <= r_rpm;
            left_err_reg   <= l_err;
            right_err_reg  <= r_err;
        end
    end

    assign result_valid = out_valid_reg;
    assign left_duty    = left_duty_reg;
    assign right_duty   = right_duty_reg;
    assign left_rpm     = left_rpm_reg;
    assign right_rpm    = right_rpm_reg;
    assign left_error   = left_err_reg;
    assign right_error  = right_err_reg;

endmodule

// File: dv/tb_dual_wheel_pi_speed_controller.sv
// Self-checking testbench for the dual wheel PI speed controller.
// Depends on rtl/dwpi_pkg.sv and rtl/dual_wheel_pi_speed_controller.sv; the expected
// duties, speeds and errors come from a predictor of the control step kept in this file.
module tb_dual_wheel_pi_speed_controller;
    import dwpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [PERIOD_W-1:0] left;
        logic [PERIOD_W-1:0] right;
    } tach_pair_t;

    typedef struct packed {
        logic [DUTY_W-1:0] l_duty;
        logic [DUTY_W-1:0] r_duty;
        logic [RPM_W-1:0]  l_rpm;
        logic [RPM_W-1:0]  r_rpm;
        logic [ERR_W-1:0]  l_err;
        logic [ERR_W-1:0]  r_err;
    } wheel_update_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    logic [PERIOD_W-1:0]   left_period = '0;
    logic [PERIOD_W-1:0]   right_period = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [DUTY_W-1:0]     left_duty;
    logic [DUTY_W-1:0]     right_duty;
    logic [RPM_W-1:0]      left_rpm;
    logic [RPM_W-1:0]      right_rpm;
    logic signed [ERR_W-1:0] left_error;
    logic signed [ERR_W-1:0] right_error;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state and register copies.
    cfg_t              settings;
    logic              loop_on;
    logic [PERIOD_W-1:0] l_hist [HIST_DEPTH];
    logic [PERIOD_W-1:0] r_hist [HIST_DEPTH];
    int unsigned       hist_slot;
    logic [SUM_W-1:0]  l_sum;
    logic [SUM_W-1:0]  r_sum;
    logic [DUTY_W-1:0] l_drive;
    logic [DUTY_W-1:0] r_drive;
    int                l_last_err;
    int                r_last_err;

    tach_pair_t    tach_backlog [$];
    wheel_update_t updates_due [$];
    tach_pair_t    next_pair;
    wheel_update_t due;
    bit            steady_flow = 1'b0;
    int            mismatches = 0;
    int unsigned   cycle_count = 0;

    dual_wheel_pi_speed_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .left_period  (left_period),
        .right_period (right_period),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .left_duty    (left_duty),
        .right_duty   (right_duty),
        .left_rpm     (left_rpm),
        .right_rpm    (right_rpm),
        .left_error   (left_error),
        .right_error  (right_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [RPM_W-1:0] wheel_speed(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0]  avg;
        logic [CONV_W-1:0] quot;
        avg = sum / SUM_W'(HIST_DEPTH);
        if (avg == '0)
            return '1;
        quot = settings.conv / avg;
        return (quot > CONV_W'(16'hFFFF)) ? '1 : quot[RPM_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] pi_update(inout logic [DUTY_W-1:0] drive,
                                                    inout int last_err, input int err);
        longint ka;
        longint kb;
        longint x;
        longint y;
        ka = longint'(settings.pgain) + longint'(settings.igain);
        kb = longint'(settings.igain) - longint'(settings.pgain);
        x = longint'(drive) + ka * longint'(err) + kb * longint'(last_err);
        // Floor above ceiling: the floor wins only for x below it.
        if (x < longint'(settings.floor_duty))
            y = longint'(settings.floor_duty);
        else if (x > longint'(settings.ceil_duty))
            y = longint'(settings.ceil_duty);
        else
            y = x;
        drive = y[DUTY_W-1:0];
        last_err = err;
        return drive;
    endfunction

    function automatic void run_control_step(input logic [PERIOD_W-1:0] lp,
                                             input logic [PERIOD_W-1:0] rp);
        int unsigned   slot;
        int            l_err;
        int            r_err;
        wheel_update_t upd;
        if (!loop_on)
            return;
        slot = (hist_slot >= HIST_DEPTH) ? 0 : hist_slot;
        l_sum = l_sum - l_hist[slot] + lp;
        r_sum = r_sum - r_hist[slot] + rp;
        l_hist[slot] = lp;
        r_hist[slot] = rp;
        hist_slot = (slot + 1 >= HIST_DEPTH) ? 0 : slot + 1;
        upd.l_rpm = wheel_speed(l_sum);
        upd.r_rpm = wheel_speed(r_sum);
        l_err = int'(settings.target) - int'(upd.l_rpm);
        r_err = int'(settings.target) - int'(upd.r_rpm);
        upd.l_err = l_err[ERR_W-1:0];
        upd.r_err = r_err[ERR_W-1:0];
        upd.l_duty = pi_update(l_drive, l_last_err, l_err);
        upd.r_duty = pi_update(r_drive, r_last_err, r_err);
        updates_due.push_back(upd);
    endfunction

    function automatic void check_field(input string name, input logic [ERR_W-1:0] want,
                                        input logic [ERR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Request driver: predicts on acceptance, then offers the next pending pair.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            left_period <= '0;
            right_period <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                run_control_step(left_period, right_period);
            if (!item_valid || !item_stall)
            begin
                if (tach_backlog.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 9))
                begin
                    next_pair = tach_backlog.pop_front();
                    item_valid <= 1'b1;
                    left_period <= next_pair.left;
                    right_period <= next_pair.right;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (updates_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, duties %0d %0d",
                             $time, left_duty, right_duty);
                    mismatches++;
                end
                else
                begin
                    due = updates_due.pop_front();
                    check_field("left_duty", ERR_W'(due.l_duty), ERR_W'(left_duty));
                    check_field("right_duty", ERR_W'(due.r_duty), ERR_W'(right_duty));
                    check_field("left_rpm", ERR_W'(due.l_rpm), ERR_W'(left_rpm));
                    check_field("right_rpm", ERR_W'(due.r_rpm), ERR_W'(right_rpm));
                    check_field("left_error", due.l_err, left_error);
                    check_field("right_error", due.r_err, right_error);
                end
            end
            result_stall <= !steady_flow && ($urandom_range(0, 99) < 9);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_dual_wheel_pi_speed_controller NOT OK");
            $finish;
        end
    end

    task automatic push_pair(input logic [PERIOD_W-1:0] lp, input logic [PERIOD_W-1:0] rp);
        tach_backlog.push_back({lp, rp});
    endtask

    // Waits until every request is taken and answered, then lets a request that
    // gives no result run out before anything else happens. The queues and the
    // request valid are looked at on the falling edge, once the rising edge has settled.
    task automatic wait_for_quiet();
        while (tach_backlog.size() != 0 || item_valid || updates_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TARGET:  settings.target = data[RPM_W-1:0];
            REG_PGAIN:   settings.pgain = data[GAIN_W-1:0];
            REG_IGAIN:   settings.igain = data[GAIN_W-1:0];
            REG_FLOOR:   settings.floor_duty = data[DUTY_W-1:0];
            REG_CEILING: settings.ceil_duty = data[DUTY_W-1:0];
            REG_CONV:    settings.conv = data[CONV_W-1:0];
            REG_ENABLE:  loop_on = data[0];
            default:     ;
        endcase
    endtask

    // Writes every register, with random junk above each one's width but conv's.
    task automatic program_registers(input cfg_t c, input logic en, input bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, 24'($urandom));
        write_reg(REG_TARGET, {8'($urandom), c.target});
        write_reg(REG_PGAIN, {16'($urandom), c.pgain});
        write_reg(REG_IGAIN, {16'($urandom), c.igain});
        write_reg(REG_FLOOR, {10'($urandom), c.floor_duty});
        write_reg(REG_CEILING, {10'($urandom), c.ceil_duty});
        write_reg(REG_CONV, c.conv);
        write_reg(REG_ENABLE, {23'($urandom), en});
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        case ($urandom_range(0, 5))
            0:       c.target = '0;
            1:       c.target = '1;
            2:       c.target = 16'($urandom);
            default: c.target = 16'($urandom_range(0, 3000));
        endcase
        c.pgain = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        c.igain = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0)
        begin
            c.floor_duty = 14'($urandom);
            c.ceil_duty = 14'($urandom);
        end
        else
        begin
            c.floor_duty = 14'($urandom_range(0, 500));
            c.ceil_duty = 14'($urandom_range(5000, 9999));
        end
        case ($urandom_range(0, 7))
            0:       c.conv = 24'($urandom);
            1:       c.conv = '1;
            2:       c.conv = '0;
            default: c.conv = CONV_RESET;
        endcase
        return c;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_base();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(1, 65535));
            1:       return 16'($urandom_range(1, 200));
            default: return 16'($urandom_range(500, 5000));
        endcase
    endfunction

    // Mostly a steady wheel with jitter, sometimes a glitch or a stopped wheel.
    function automatic logic [PERIOD_W-1:0] next_period(input logic [PERIOD_W-1:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'(base + $urandom_range(0, 31) - 16);
        else if (r < 80)
            return 16'($urandom);
        else if (r < 88)
            return 16'($urandom_range(0, 15));
        else if (r < 93)
            return '0;
        else
            return '1;
    endfunction

    task automatic run_random(input int count, input bit quiet);
        logic [PERIOD_W-1:0] l_base;
        logic [PERIOD_W-1:0] r_base;
        l_base = pick_base();
        r_base = pick_base();
        steady_flow = quiet;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 19)
            begin
                l_base = pick_base();
                r_base = pick_base();
            end
            push_pair(next_period(l_base), next_period(r_base));
        end
        wait_for_quiet();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        cfg_t c;
        settings = '{target: TARGET_RESET, pgain: PGAIN_RESET, igain: IGAIN_RESET,
                     floor_duty: FLOOR_RESET, ceil_duty: CEILING_RESET, conv: CONV_RESET};
        loop_on = 1'b0;
        foreach (l_hist[i])
        begin
            l_hist[i] = '0;
            r_hist[i] = '0;
        end
        hist_slot = 0;
        l_sum = '0;
        r_sum = '0;
        l_drive = '0;
        r_drive = '0;
        l_last_err = 0;
        r_last_err = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // The loop is off after reset: these requests must leave no trace.
        push_pair(16'hFFFF, 16'h1234);
        push_pair(16'h0001, 16'hFFFF);
        push_pair(16'h00AA, 16'h5555);
        wait_for_quiet();

        // Reset gains with the loop on; zero, full scale, and tiny periods, of which the smallest
        // drives the quotient past sixteen bits.
        c = settings;
        program_registers(c, 1'b1, 1'b1);
        push_pair(16'h0000, 16'h0000);
        push_pair(16'hFFFF, 16'h0000);
        push_pair(16'h0000, 16'hFFFF);
        push_pair(16'hFFFF, 16'hFFFF);
        push_pair(16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 10; i++)
            push_pair(16'd12, 16'd3);
        wait_for_quiet();

        // Zero conversion constant, floor above ceiling, largest gains and target.
        c = '{target: '1, pgain: '1, igain: '1, floor_duty: '1, ceil_duty: '0, conv: '0};
        program_registers(c, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            push_pair(16'($urandom), 16'($urandom));
        wait_for_quiet();

        // Largest conversion constant, zero target, widest duty range.
        c = '{target: '0, pgain: '0, igain: '1, floor_duty: '0, ceil_duty: '1, conv: '1};
        program_registers(c, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            push_pair(16'($urandom_range(0, 40)), 16'($urandom));
        wait_for_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            c = random_settings();
            if (ph == 5)
            begin
                program_registers(c, 1'b0, 1'b1);
                run_random(30, 1'b0);
            end
            else
            begin
                program_registers(c, 1'b1, ph == 3);
                run_random(110, ph == 0);
            end
        end

        if (mismatches == 0 && updates_due.size() == 0)
            $display("tb_dual_wheel_pi_speed_controller OK");
        else
            $display("tb_dual_wheel_pi_speed_controller NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dwpi_pkg.sv
rtl/dwpi_div.sv
rtl/dwpi_mac.sv
rtl/dwpi_lane.sv
rtl/dual_wheel_pi_speed_controller.sv
dv/tb_dual_wheel_pi_speed_controller.sv
